FILE: rtl/gwsm_pkg.sv
// shared types, constants and helpers for the gauge wave speed block
package gwsm_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 24;
   localparam int KAPPA_BITS = WORD_BITS - 1;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_DATA_MODE   = 2'd0;
   localparam logic [1:0] CSR_SHOCK_AVOID = 2'd1;
   localparam logic [1:0] CSR_KAPPA       = 2'd2;

   // data modes
   localparam logic [1:0] MODE_2D = 2'd0;
   localparam logic [1:0] MODE_3D = 2'd1;

   // axis codes of the speed loop
   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Z = 2'd1;
   localparam logic [1:0] AX_Y = 2'd2;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] metric_xx;
      logic signed [WORD_BITS-1:0] metric_xy;
      logic signed [WORD_BITS-1:0] metric_xz;
      logic signed [WORD_BITS-1:0] metric_yy;
      logic signed [WORD_BITS-1:0] metric_yz;
      logic signed [WORD_BITS-1:0] metric_zz;
      logic signed [WORD_BITS-1:0] lapse;
      logic                        last_point;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] speed_x;
      logic [WORD_BITS-1:0] speed_y;
      logic [WORD_BITS-1:0] speed_z;
      logic                 speeds_valid;
      logic                 det_zero;
      logic [WORD_BITS-1:0] wave_speed;
      logic                 wave_speed_valid;
   } rsp_type;

   typedef struct packed {
      logic three_d;
      logic speed_on;
      logic last;
      logic wave_ok;
   } class_type;

   typedef struct packed {
      req_type   item;
      class_type cls;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_COF,
      ST_DET,
      ST_DETF,
      ST_MUL,
      ST_DIVS,
      ST_DIV,
      ST_SQRT,
      ST_NEXT,
      ST_FIN
   } back_state_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   function automatic logic [63:0] mag65(input logic signed [64:0] v);
      logic [64:0] r;
      r = v[64] ? 65'(-v) : 65'(v);
      return r[63:0];
   endfunction

   function automatic logic signed [31:0] pick32(input logic [1:0] s,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic signed [31:0] c);
      logic signed [31:0] r;
      case (s)
         2'd0: r = a;
         2'd1: r = b;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic signed [64:0] pick65(input logic [1:0] s,
                                                  input logic signed [64:0] a,
                                                  input logic signed [64:0] b,
                                                  input logic signed [64:0] c);
      logic signed [64:0] r;
      case (s)
         2'd0: r = a;
         2'd1: r = b;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/gwsm_queue.sv
// short fifo of classified words between front and back
module gwsm_queue import gwsm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type stat
);

   entry_type             mem_ff [0:Q_DEPTH-1];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/gwsm_front.sv
// input side: takes words and tags them with their mode flags
module gwsm_front import gwsm_pkg::*; (
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_word,
   input  logic [1:0]      data_mode,
   input  logic            shock_avoid_enable,
   input  qstat_type       qstat,
   output logic            push,
   output entry_type       push_entry
);

   class_type cls;

   always_comb begin
      cls.three_d  = (data_mode == MODE_3D);
      cls.speed_on = shock_avoid_enable;
      cls.last     = req_word.last_point;
      cls.wave_ok  = req_word.last_point &&
                     (data_mode == MODE_2D || data_mode == MODE_3D);
   end

   assign req_stall       = qstat.full;
   assign push            = req_valid && !qstat.full;
   assign push_entry.item = req_word;
   assign push_entry.cls  = cls;

endmodule

FILE: rtl/gwsm_back.sv
// compute side: products, determinant, divide, root, maxima and result register
module gwsm_back import gwsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  qstat_type             qstat,
   input  entry_type             head,
   output logic                  pop,
   input  logic [KAPPA_BITS-1:0] kappa,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_word
);

   back_state_type     state_ff, state_in;
   logic [6:0]         cnt_ff, cnt_in, cnt_inc, prv;
   entry_type          entry_ff, entry_in;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;
   logic signed [63:0] p_ff [0:10];
   logic signed [63:0] p_in [0:10];
   logic signed [64:0] cof_ff [0:4];
   logic signed [64:0] cof_in [0:4];
   logic [63:0]        amp_ff, amp_in;
   logic [127:0]       acc_ff, acc_in;
   logic               dz_ff, dz_in;
   logic [96:0]        absdet_ff, absdet_in;
   logic [1:0]         axis_ff, axis_in;
   logic [96:0]        rem_ff, rem_in;
   logic [63:0]        pl_ff, pl_in;
   logic [63:0]        q_ff, q_in;
   logic [32:0]        srem_ff, srem_in;
   logic [31:0]        root_ff, root_in;
   logic [31:0]        spd_ff [0:2];
   logic [31:0]        spd_in [0:2];
   logic [31:0]        max_ff [0:2];
   logic [31:0]        max_in [0:2];
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic signed [31:0] iss_x, prv_x;
   logic signed [64:0] iss_c, prv_c, ax_c;
   logic [63:0]        iss_cm, ax_cm;
   logic [127:0]       det_term, mul_term, neg_acc;
   logic               det_neg;
   logic [97:0]        div_t, div_d;
   logic               div_ge;
   logic [34:0]        sq_r2, sq_tr, sq_d;
   logic               sq_ge;
   logic [31:0]        root_nx;
   logic [31:0]        mx [0:2];
   logic [31:0]        wave_xz, wave;
   logic               out_free;

   assign cnt_inc = cnt_ff + 7'd1;
   assign prv     = cnt_ff - 7'd1;

   // determinant = xx*cx - xy*t1 + xz*t2
   assign iss_x  = pick32(cnt_ff[2:1], entry_ff.item.metric_xx, entry_ff.item.metric_xy,
                          entry_ff.item.metric_xz);
   assign prv_x  = pick32(prv[2:1], entry_ff.item.metric_xx, entry_ff.item.metric_xy,
                          entry_ff.item.metric_xz);
   assign iss_c  = pick65(cnt_ff[2:1], cof_ff[0], cof_ff[3], cof_ff[4]);
   assign prv_c  = pick65(prv[2:1], cof_ff[0], cof_ff[3], cof_ff[4]);
   assign iss_cm = mag65(iss_c);
   assign det_neg = prv_x[31] ^ prv_c[64] ^ (prv[2:1] == 2'd1);
   assign det_term = prv[0] ? {32'b0, prod_ff[63:0], 32'b0} : {64'b0, prod_ff[63:0]};

   // cofactor of the current axis
   always_comb begin
      case (axis_ff)
         AX_X: ax_c = cof_ff[0];
         AX_Z: ax_c = cof_ff[2];
         default: ax_c = cof_ff[1];
      endcase
   end
   assign ax_cm = mag65(ax_c);

   always_comb begin
      case (prv[1:0])
         2'd0: mul_term = {64'b0, prod_ff[63:0]};
         2'd3: mul_term = {prod_ff[63:0], 64'b0};
         default: mul_term = {32'b0, prod_ff[63:0], 32'b0};
      endcase
   end

   assign neg_acc = 128'(-acc_ff);

   // restoring divide, one quotient bit a cycle
   assign div_t  = {rem_ff, pl_ff[63]};
   assign div_ge = (div_t >= {1'b0, absdet_ff});
   assign div_d  = div_t - {1'b0, absdet_ff};

   // digit-by-digit root, two radicand bits a cycle
   assign sq_r2   = {srem_ff, q_ff[63:62]};
   assign sq_tr   = {1'b0, root_ff, 2'b01};
   assign sq_ge   = (sq_r2 >= sq_tr);
   assign sq_d    = sq_r2 - sq_tr;
   assign root_nx = {root_ff[30:0], sq_ge};

   assign mx[0]   = (spd_ff[0] > max_ff[0]) ? spd_ff[0] : max_ff[0];
   assign mx[1]   = (spd_ff[1] > max_ff[1]) ? spd_ff[1] : max_ff[1];
   assign mx[2]   = (spd_ff[2] > max_ff[2]) ? spd_ff[2] : max_ff[2];
   assign wave_xz = (mx[0] > mx[1]) ? mx[0] : mx[1];
   assign wave    = (entry_ff.cls.three_d && mx[2] > wave_xz) ? mx[2] : wave_xz;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      entry_in     = entry_ff;
      p_in         = p_ff;
      cof_in       = cof_ff;
      amp_in       = amp_ff;
      acc_in       = acc_ff;
      dz_in        = dz_ff;
      absdet_in    = absdet_ff;
      axis_in      = axis_ff;
      rem_in       = rem_ff;
      pl_in        = pl_ff;
      q_in         = q_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      spd_in       = spd_ff;
      max_in       = max_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      pop          = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop       = 1'b1;
               entry_in  = head;
               cnt_in    = '0;
               spd_in[0] = '0;
               spd_in[1] = '0;
               spd_in[2] = '0;
               state_in  = ST_PROD;
            end
         end
         ST_PROD: begin
            case (cnt_ff[3:0])
               4'd0: begin
                  mul_a = 33'(entry_ff.item.metric_yy);
                  mul_b = 33'(entry_ff.item.metric_zz);
               end
               4'd1: begin
                  mul_a = 33'(entry_ff.item.metric_yz);
                  mul_b = 33'(entry_ff.item.metric_yz);
               end
               4'd2: begin
                  mul_a = 33'(entry_ff.item.metric_xx);
                  mul_b = 33'(entry_ff.item.metric_zz);
               end
               4'd3: begin
                  mul_a = 33'(entry_ff.item.metric_xz);
                  mul_b = 33'(entry_ff.item.metric_xz);
               end
               4'd4: begin
                  mul_a = 33'(entry_ff.item.metric_xx);
                  mul_b = 33'(entry_ff.item.metric_yy);
               end
               4'd5: begin
                  mul_a = 33'(entry_ff.item.metric_xy);
                  mul_b = 33'(entry_ff.item.metric_xy);
               end
               4'd6: begin
                  mul_a = 33'(entry_ff.item.metric_xy);
                  mul_b = 33'(entry_ff.item.metric_zz);
               end
               4'd7: begin
                  mul_a = 33'(entry_ff.item.metric_xz);
                  mul_b = 33'(entry_ff.item.metric_yz);
               end
               4'd8: begin
                  mul_a = 33'(entry_ff.item.metric_xy);
                  mul_b = 33'(entry_ff.item.metric_yz);
               end
               4'd9: begin
                  mul_a = 33'(entry_ff.item.metric_xz);
                  mul_b = 33'(entry_ff.item.metric_yy);
               end
               4'd10: begin
                  mul_a = 33'(entry_ff.item.lapse);
                  mul_b = 33'(entry_ff.item.lapse);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
            // product of the previous cycle lands here
            if (cnt_ff != '0) begin
               p_in[prv[3:0]] = prod_ff[63:0];
            end
            if (cnt_ff == 7'd11) begin
               state_in = ST_COF;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         ST_COF: begin
            cof_in[0] = {p_ff[0][63], p_ff[0]} - {p_ff[1][63], p_ff[1]};
            cof_in[1] = {p_ff[2][63], p_ff[2]} - {p_ff[3][63], p_ff[3]};
            cof_in[2] = {p_ff[4][63], p_ff[4]} - {p_ff[5][63], p_ff[5]};
            cof_in[3] = {p_ff[6][63], p_ff[6]} - {p_ff[7][63], p_ff[7]};
            cof_in[4] = {p_ff[8][63], p_ff[8]} - {p_ff[9][63], p_ff[9]};
            amp_in    = p_ff[10] + {9'b0, kappa, 24'b0};
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = ST_DET;
         end
         ST_DET: begin
            if (cnt_ff < 7'd6) begin
               mul_a = {1'b0, mag32(iss_x)};
               mul_b = {1'b0, cnt_ff[0] ? iss_cm[63:32] : iss_cm[31:0]};
            end
            if (cnt_ff != '0) begin
               acc_in = det_neg ? acc_ff - det_term : acc_ff + det_term;
            end
            if (cnt_ff == 7'd6) begin
               state_in = ST_DETF;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         ST_DETF: begin
            dz_in     = (acc_ff == '0);
            absdet_in = acc_ff[127] ? neg_acc[96:0] : acc_ff[96:0];
            axis_in   = AX_X;
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = entry_ff.cls.speed_on ? ST_MUL : ST_FIN;
         end
         ST_MUL: begin
            if (dz_ff) begin
               spd_in[axis_ff] = '1;
               state_in        = ST_NEXT;
            end else begin
               if (cnt_ff < 7'd4) begin
                  mul_a = {1'b0, cnt_ff[1] ? amp_ff[63:32] : amp_ff[31:0]};
                  mul_b = {1'b0, cnt_ff[0] ? ax_cm[63:32] : ax_cm[31:0]};
               end
               if (cnt_ff != '0) begin
                  acc_in = acc_ff + mul_term;
               end
               if (cnt_ff == 7'd4) begin
                  state_in = ST_DIVS;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
         end
         ST_DIVS: begin
            // quotient of 2^64 or more saturates the speed
            if ({9'b0, acc_ff[127:40]} >= absdet_ff) begin
               spd_in[axis_ff] = '1;
               state_in        = ST_NEXT;
            end else begin
               rem_in   = {9'b0, acc_ff[127:40]};
               pl_in    = {acc_ff[39:0], 24'b0};
               q_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? div_d[96:0] : div_t[96:0];
            pl_in  = {pl_ff[62:0], 1'b0};
            q_in   = {q_ff[62:0], div_ge};
            if (cnt_ff == 7'd63) begin
               cnt_in   = '0;
               srem_in  = '0;
               root_in  = '0;
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         ST_SQRT: begin
            srem_in = sq_ge ? sq_d[32:0] : sq_r2[32:0];
            root_in = root_nx;
            q_in    = {q_ff[61:0], 2'b00};
            if (cnt_ff == 7'd31) begin
               spd_in[axis_ff] = root_nx;
               state_in        = ST_NEXT;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         ST_NEXT: begin
            acc_in = '0;
            cnt_in = '0;
            if (axis_ff == AX_X) begin
               axis_in  = AX_Z;
               state_in = ST_MUL;
            end else if (axis_ff == AX_Z && entry_ff.cls.three_d) begin
               axis_in  = AX_Y;
               state_in = ST_MUL;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_in.speed_x          = spd_ff[0];
               out_in.speed_y          = spd_ff[2];
               out_in.speed_z          = spd_ff[1];
               out_in.speeds_valid     = entry_ff.cls.speed_on;
               out_in.det_zero         = dz_ff;
               out_in.wave_speed       = entry_ff.cls.wave_ok ? wave : '0;
               out_in.wave_speed_valid = entry_ff.cls.wave_ok;
               out_valid_in            = 1'b1;
               if (entry_ff.cls.last) begin
                  max_in[0] = '0;
                  max_in[1] = '0;
                  max_in[2] = '0;
               end else begin
                  max_in = mx;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         max_ff[0]    <= '0;
         max_ff[1]    <= '0;
         max_ff[2]    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= mul_a * mul_b;
      entry_ff  <= entry_in;
      p_ff      <= p_in;
      cof_ff    <= cof_in;
      amp_ff    <= amp_in;
      acc_ff    <= acc_in;
      dz_ff     <= dz_in;
      absdet_ff <= absdet_in;
      axis_ff   <= axis_in;
      rem_ff    <= rem_in;
      pl_ff     <= pl_in;
      q_ff      <= q_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      spd_ff    <= spd_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

FILE: rtl/gauge_wave_speed_max.sv
// top level: configuration registers, front, queue and back
// Gauge wave speed with running maximum. Each request word is one grid point
// (six metric components and the lapse, signed Q8.24); each word gives one
// response word with the x, z and (3D mode) y speeds (shock avoidance on),
// flags, and on the last point in 2D or 3D mode the sweep maximum. Points
// go through one at a time on the shared 33x33 multiplier (eleven metric
// products, six determinant partial products, four partial products per
// axis), the 64-step restoring divider and the 32-step root per axis; the
// per-axis work is skipped when shock avoidance is off, and the divide and
// root when the determinant is zero. A two-word queue lets the request side
// run ahead, and the response register frees the compute side while a
// finished word waits. Configuration must be written by the user only
// while the block is idle; the block itself does not enforce it.
module gauge_wave_speed_max import gwsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_word,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [KAPPA_BITS-1:0] csr_wdata
);

   logic [1:0]            data_mode_ff, data_mode_in;
   logic                  shock_ff, shock_in;
   logic [KAPPA_BITS-1:0] kappa_ff, kappa_in;

   logic      push, pop;
   entry_type push_entry, head;
   qstat_type qstat;

   always_comb begin
      data_mode_in = data_mode_ff;
      shock_in     = shock_ff;
      kappa_in     = kappa_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DATA_MODE:   data_mode_in = csr_wdata[1:0];
            CSR_SHOCK_AVOID: shock_in     = csr_wdata[0];
            CSR_KAPPA:       kappa_in     = csr_wdata;
            default: begin
               data_mode_in = data_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_mode_ff <= MODE_2D;
         shock_ff     <= 1'b0;
         kappa_ff     <= '0;
      end else begin
         data_mode_ff <= data_mode_in;
         shock_ff     <= shock_in;
         kappa_ff     <= kappa_in;
      end
   end

   gwsm_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_word           (req_word),
      .data_mode          (data_mode_ff),
      .shock_avoid_enable (shock_ff),
      .qstat              (qstat),
      .push               (push),
      .push_entry         (push_entry)
   );

   gwsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   gwsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head      (head),
      .pop       (pop),
      .kappa     (kappa_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: tb/sv/testbench.sv
// testbench for the gauge wave speed block: directed table, then random sweeps
module testbench;
   import gwsm_pkg::*;

   localparam int          POINTS_PER_SWEEP = 325;
   localparam int          SWEEPS           = 6;
   localparam int          CYCLE_LIMIT      = 4000000;
   localparam logic [31:0] ONE_Q            = 32'h0100_0000;
   localparam logic [31:0] SPEED_SAT        = 32'hFFFF_FFFF;
   localparam logic [KAPPA_BITS-1:0] KAPPA_MAX = '1;
   localparam logic [1:0]  MODE_OTHER       = 2'd2;
   localparam logic [1:0]  MODE_SPARE       = 2'd3;

   typedef struct {
      logic [1:0]            mode;
      logic                  shock;
      logic [KAPPA_BITS-1:0] kappa;
      req_type               word;
      logic                  typed;
      rsp_type               want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_word;
   logic                  csr_wr_en;
   logic [1:0]            csr_index;
   logic [KAPPA_BITS-1:0] csr_wdata;

   // own copy of configuration and sweep maxima
   logic [1:0]            cur_mode;
   logic                  cur_shock;
   logic [KAPPA_BITS-1:0] cur_kappa;
   logic [31:0]           peak_x, peak_y, peak_z;

   rsp_type     speeds_due[$];
   dir_row_type dir_tab[$];
   logic        typed_next;
   rsp_type     typed_want;
   int          send_idle_pct, recv_idle_pct;
   int          fails, cycles, words_seen, sweeps_closed;

   gauge_wave_speed_max DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] axis_speed(logic [63:0] amp, logic signed [99:0] cof,
                                              logic [99:0] abs_det);
      logic [99:0]  c;
      logic [159:0] p, q;
      logic [31:0]  s, cand;
      c = cof[99] ? 100'(-cof) : 100'(cof);
      p = (160'(amp) * 160'(c)) << FRAC_BITS;
      q = p / 160'(abs_det);
      if (q[159:64] != '0) return SPEED_SAT;
      s = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = s | (32'd1 << b);
         if (64'(cand) * 64'(cand) <= q[63:0]) s = cand;
      end
      return s;
   endfunction

   // speeds of one grid point; updates the sweep maxima
   function automatic rsp_type predict_point(req_type w);
      logic signed [99:0] xx, xy, xz, yy, yz, zz, cx, cy, cz, det;
      logic signed [63:0] lp;
      logic [63:0]        amp;
      logic [99:0]        abs_det;
      logic               dz, three_d;
      rsp_type            r;
      xx = w.metric_xx; xy = w.metric_xy; xz = w.metric_xz;
      yy = w.metric_yy; yz = w.metric_yz; zz = w.metric_zz;
      lp = w.lapse;
      three_d = (cur_mode == MODE_3D);
      cx = yy * zz - yz * yz;
      cy = xx * zz - xz * xz;
      cz = xx * yy - xy * xy;
      det = xx * cx - xy * (xy * zz - xz * yz) + xz * (xy * yz - xz * yy);
      dz = (det == 0);
      abs_det = det[99] ? 100'(-det) : 100'(det);
      amp = 64'(lp * lp) + ({33'd0, cur_kappa} << FRAC_BITS);
      r = '0;
      if (cur_shock) begin
         r.speed_x = dz ? SPEED_SAT : axis_speed(amp, cx, abs_det);
         r.speed_z = dz ? SPEED_SAT : axis_speed(amp, cz, abs_det);
         if (three_d) r.speed_y = dz ? SPEED_SAT : axis_speed(amp, cy, abs_det);
      end
      r.speeds_valid = cur_shock;
      r.det_zero = dz;
      if (r.speed_x > peak_x) peak_x = r.speed_x;
      if (r.speed_y > peak_y) peak_y = r.speed_y;
      if (r.speed_z > peak_z) peak_z = r.speed_z;
      if (w.last_point) begin
         if (cur_mode == MODE_2D || cur_mode == MODE_3D) begin
            r.wave_speed_valid = 1'b1;
            r.wave_speed = (peak_x > peak_z) ? peak_x : peak_z;
            if (three_d && peak_y > r.wave_speed) r.wave_speed = peak_y;
         end
         peak_x = '0;
         peak_y = '0;
         peak_z = '0;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fails++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // request side: prediction on every accepted word; response side: check of every taken word
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         rsp_type p;
         p = predict_point(req_word);
         if (req_word.last_point) sweeps_closed++;
         speeds_due.push_back(typed_next ? typed_want : p);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_type e;
         words_seen++;
         if (speeds_due.size() == 0) begin
            fails++;
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_word);
         end else begin
            e = speeds_due.pop_front();
            check_field("speed_x", e.speed_x, rsp_word.speed_x);
            check_field("speed_y", e.speed_y, rsp_word.speed_y);
            check_field("speed_z", e.speed_z, rsp_word.speed_z);
            check_field("speeds_valid", 32'(e.speeds_valid), 32'(rsp_word.speeds_valid));
            check_field("det_zero", 32'(e.det_zero), 32'(rsp_word.det_zero));
            check_field("wave_speed", e.wave_speed, rsp_word.wave_speed);
            check_field("wave_speed_valid", 32'(e.wave_speed_valid),
                        32'(rsp_word.wave_speed_valid));
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_point(req_type w, logic typed, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word = w;
      typed_next = typed;
      typed_want = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (speeds_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [KAPPA_BITS-1:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_config(logic [1:0] mode, logic shock, logic [KAPPA_BITS-1:0] kap);
      settle();
      write_csr(CSR_DATA_MODE, {{(KAPPA_BITS-2){1'b0}}, mode});
      write_csr(CSR_SHOCK_AVOID, {{(KAPPA_BITS-1){1'b0}}, shock});
      write_csr(CSR_KAPPA, kap);
      cur_mode = mode;
      cur_shock = shock;
      cur_kappa = kap;
   endtask

   function automatic req_type diag_point(logic [31:0] g, logic [31:0] lapse, logic last);
      req_type w;
      w = '0;
      w.metric_xx = g;
      w.metric_yy = g;
      w.metric_zz = g;
      w.lapse = lapse;
      w.last_point = last;
      return w;
   endfunction

   function automatic req_type fill_point(logic [31:0] v, logic last);
      req_type w;
      w = {{7{v}}, last};
      return w;
   endfunction

   function automatic rsp_type flat_word(logic [31:0] s, logic on, logic dz,
                                         logic [31:0] wave, logic wv);
      rsp_type r;
      r = '{s, s, s, on, dz, wave, wv};
      return r;
   endfunction

   function automatic void add_row(logic [1:0] mode, logic shock, logic [KAPPA_BITS-1:0] kap,
                                   req_type w, logic typed, rsp_type want);
      dir_row_type r;
      r = '{mode, shock, kap, w, typed, want};
      dir_tab.push_back(r);
   endfunction

   function automatic logic [31:0] near_one();
      return ONE_Q + 32'($signed($urandom_range(2 * ONE_Q)) - $signed(ONE_Q / 2));
   endfunction

   function automatic logic [31:0] small_off();
      return 32'($signed($urandom_range(ONE_Q / 2)) - $signed(ONE_Q / 4));
   endfunction

   function automatic req_type random_point();
      req_type w;
      int      a, b, c, kind;
      kind = $urandom_range(99);
      if (kind < 60) begin
         // well-behaved metric near unity
         w.metric_xx = near_one();
         w.metric_yy = near_one();
         w.metric_zz = near_one();
         w.metric_xy = small_off();
         w.metric_xz = small_off();
         w.metric_yz = small_off();
         w.lapse = near_one();
      end else if (kind < 75) begin
         // rank one metric: determinant exactly zero
         a = $urandom_range(4096) - 2048;
         b = $urandom_range(4096) - 2048;
         c = $urandom_range(4096) - 2048;
         w.metric_xx = a * a; w.metric_xy = a * b; w.metric_xz = a * c;
         w.metric_yy = b * b; w.metric_yz = b * c; w.metric_zz = c * c;
         w.lapse = $urandom;
      end else begin
         w.metric_xx = $urandom; w.metric_xy = $urandom; w.metric_xz = $urandom;
         w.metric_yy = $urandom; w.metric_yz = $urandom; w.metric_zz = $urandom;
         w.lapse = $urandom;
      end
      w.last_point = ($urandom_range(19) == 0);
      return w;
   endfunction

   initial begin
      logic [1:0]            sweep_mode  [SWEEPS];
      logic                  sweep_shock [SWEEPS];
      logic [KAPPA_BITS-1:0] sweep_kappa [SWEEPS];
      rsp_type               none;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_DATA_MODE;
      csr_wdata = '0;
      typed_next = 1'b0;
      typed_want = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fails = 0;
      cycles = 0;
      words_seen = 0;
      sweeps_closed = 0;
      cur_mode = MODE_2D;
      cur_shock = 1'b0;
      cur_kappa = '0;
      peak_x = '0;
      peak_y = '0;
      peak_z = '0;
      none = '0;

      // after reset: 2D and then other mode, speeds off
      add_row(MODE_2D, 1'b0, '0, diag_point(ONE_Q, ONE_Q, 1'b0), 1'b1,
              flat_word('0, 1'b0, 1'b0, '0, 1'b0));
      add_row(MODE_2D, 1'b0, '0, fill_point('0, 1'b0), 1'b1,
              flat_word('0, 1'b0, 1'b1, '0, 1'b0));
      add_row(MODE_2D, 1'b0, '0, diag_point(ONE_Q, ONE_Q, 1'b1), 1'b1,
              flat_word('0, 1'b0, 1'b0, '0, 1'b1));
      add_row(MODE_OTHER, 1'b0, '0, diag_point(ONE_Q, ONE_Q, 1'b1), 1'b1,
              flat_word('0, 1'b0, 1'b0, '0, 1'b0));
      // unit metric and lapse give unit speeds
      add_row(MODE_3D, 1'b1, '0, diag_point(ONE_Q, ONE_Q, 1'b0), 1'b1,
              flat_word(ONE_Q, 1'b1, 1'b0, '0, 1'b0));
      add_row(MODE_3D, 1'b1, '0, diag_point(ONE_Q, ONE_Q, 1'b1), 1'b1,
              flat_word(ONE_Q, 1'b1, 1'b0, ONE_Q, 1'b1));
      // singular metric saturates
      add_row(MODE_3D, 1'b1, '0, fill_point('0, 1'b0), 1'b1,
              flat_word(SPEED_SAT, 1'b1, 1'b1, '0, 1'b0));
      add_row(MODE_3D, 1'b1, '0, fill_point(ONE_Q, 1'b1), 1'b1,
              flat_word(SPEED_SAT, 1'b1, 1'b1, SPEED_SAT, 1'b1));
      // extremes and mixed cases, checked by prediction
      add_row(MODE_3D, 1'b1, KAPPA_MAX, diag_point(32'h8000_0000, 32'h8000_0000, 1'b0), 1'b0, none);
      add_row(MODE_3D, 1'b1, KAPPA_MAX, diag_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0), 1'b0, none);
      add_row(MODE_3D, 1'b1, KAPPA_MAX, diag_point(32'h0000_0001, 32'h0000_0000, 1'b0), 1'b0, none);
      add_row(MODE_3D, 1'b1, KAPPA_MAX, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b0, none);
      add_row(MODE_2D, 1'b1, '0, '{32'h0200_0000, 32'h0080_0000, 32'hFF80_0000,
              32'h0100_0000, 32'h0040_0000, 32'h0300_0000, 32'hFFFF_FFFF, 1'b0}, 1'b0, none);
      add_row(MODE_2D, 1'b1, '0, diag_point(32'hFF00_0000, 32'h0180_0000, 1'b1), 1'b0, none);
      add_row(MODE_SPARE, 1'b1, 31'h0100_0000, diag_point(ONE_Q, '0, 1'b0), 1'b0, none);
      add_row(MODE_SPARE, 1'b1, 31'h0100_0000, diag_point(32'h0040_0000, ONE_Q, 1'b1), 1'b0, none);
      add_row(MODE_3D, 1'b0, KAPPA_MAX, fill_point(32'h7FFF_FFFF, 1'b1), 1'b0, none);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         if (i == 0 || dir_tab[i].mode != cur_mode || dir_tab[i].shock != cur_shock ||
             dir_tab[i].kappa != cur_kappa)
            set_config(dir_tab[i].mode, dir_tab[i].shock, dir_tab[i].kappa);
         send_point(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
      end

      sweep_mode  = '{MODE_2D, MODE_3D, MODE_3D, MODE_OTHER, MODE_2D, MODE_3D};
      sweep_shock = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      sweep_kappa = '{31'($urandom), '0, KAPPA_MAX, 31'($urandom_range(ONE_Q)),
                      31'($urandom), 31'($urandom_range(4 * ONE_Q))};
      for (int s = 0; s < SWEEPS; s++) begin
         set_config(sweep_mode[s], sweep_shock[s], sweep_kappa[s]);
         case (s / 2)
            0: begin send_idle_pct = 10; recv_idle_pct = 59; end
            1: begin send_idle_pct = 59; recv_idle_pct = 10; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < POINTS_PER_SWEEP; n++)
            send_point(random_point(), 1'b0, none);
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle();
      $display("%0d response words checked over %0d closed sweeps", words_seen, sweeps_closed);
      $display("modes 2D, 3D and other, speeds on and off, kappa from zero to full scale");
      if (fails == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
